[src/tacc_pkg.sv]
// Package for the three-alarm clock controller: event codes, view helpers,
// request, result and state types. Depends on nothing.
`default_nettype none

package tacc_pkg;

  localparam int unsigned NUM_ALARMS = 3;

  localparam logic [2:0] FN_UP_LEFT    = 3'd0;
  localparam logic [2:0] FN_UP_RIGHT   = 3'd1;
  localparam logic [2:0] FN_DOWN_LEFT  = 3'd2;
  localparam logic [2:0] FN_DOWN_RIGHT = 3'd3;
  localparam logic [2:0] FN_TICK       = 3'd4;

  localparam logic [1:0] MODE_HOME   = 2'd0;
  localparam logic [1:0] MODE_HOUR   = 2'd1;
  localparam logic [1:0] MODE_MINUTE = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;
  localparam logic [4:0] HOUR_NONE  = 5'd24;
  localparam logic [3:0] VIEW_LAST  = 4'd8;

  typedef struct packed {
    logic [2:0] func;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic       in_foreground;
  } tacc_req_t;

  typedef struct packed {
    logic [3:0] view_state;
    logic [4:0] shown_hour;
    logic [5:0] shown_minute;
    logic       shown_enabled;
    logic       shown_ringing;
    logic       blink_phase;
    logic       start_alert;
    logic       stop_alert;
    logic       exit_request;
    logic       launch_request;
    logic       redraw;
  } tacc_res_t;

  typedef struct packed {
    logic [3:0]                 view_mode;
    logic [NUM_ALARMS-1:0][4:0] hour;
    logic [NUM_ALARMS-1:0][5:0] minute;
    logic [NUM_ALARMS-1:0]      enable;
    logic [NUM_ALARMS-1:0]      ringing;
    logic                       blink;
    logic [4:0]                 last_hour;
    logic [5:0]                 last_minute;
  } tacc_state_t;

  function automatic logic [1:0] view_alarm(input logic [3:0] view);
    logic [1:0] alarm;
    case (view)
      4'd0, 4'd1, 4'd2: alarm = 2'd0;
      4'd3, 4'd4, 4'd5: alarm = 2'd1;
      default:          alarm = 2'd2;
    endcase
    return alarm;
  endfunction

  function automatic logic [1:0] view_mode_of(input logic [3:0] view);
    logic [1:0] mode;
    case (view)
      4'd0, 4'd3, 4'd6: mode = MODE_HOME;
      4'd1, 4'd4, 4'd7: mode = MODE_HOUR;
      4'd2, 4'd5, 4'd8: mode = MODE_MINUTE;
      default:          mode = MODE_NONE;
    endcase
    return mode;
  endfunction

  function automatic logic [3:0] view_of(input logic [1:0] alarm, input logic [1:0] mode);
    return 4'({alarm, 1'b0}) + 4'(alarm) + 4'(mode);
  endfunction

endpackage

`default_nettype wire

[src/tacc_if.sv]
// Valid/ready channel interfaces for the request and result sides.
// Depends on tacc_pkg.
`default_nettype none

interface tacc_in_if;
  import tacc_pkg::*;

  logic      valid;
  logic      ready;
  tacc_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tacc_out_if;
  import tacc_pkg::*;

  logic      valid;
  logic      ready;
  tacc_res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[src/three_alarm_clock_controller_top.sv]
// A request waits in a request register until the result register is free, then
// its result is registered and offered. Throughput: one request per cycle while
// results are taken; one request can still be taken while a result waits.
// Reset (asynchronous, active low): all alarms cleared and disabled, view on
// alarm one home, blink clear, last seen hour set to 24 so the first tick counts.
// Depends on tacc_pkg, tacc_if and tacc_step.
`default_nettype none

module three_alarm_clock_controller_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  tacc_in_if.sink     in_i,
  tacc_out_if.source  out_o
);
  import tacc_pkg::*;

  logic        in_valid_q;
  tacc_req_t   in_q;
  logic        out_valid_q;
  tacc_res_t   out_q;
  tacc_state_t state_q;
  tacc_state_t state_d;
  tacc_res_t   res_d;
  logic        advance;

  assign advance       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready    = !in_valid_q || advance;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  tacc_step u_step (
    .st_i  (state_q),
    .req_i (in_q),
    .nxt_o (state_d),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{view_mode: '0, hour: '0, minute: '0, enable: '0, ringing: '0,
                   blink: 1'b0, last_hour: HOUR_NONE, last_minute: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  // A held request must survive a stalled result register.
  a_hold_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("held request lost while result stalled");

  a_view_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.view_mode <= VIEW_LAST)
    else $error("view left the nine valid views");

  a_start_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.start_alert && out_q.stop_alert))
    else $error("start and stop raised in one result");

  a_launch_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.launch_request |-> out_q.start_alert && !out_q.redraw)
    else $error("launch without start, or with redraw");

  a_exit_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.exit_request |-> out_q.view_state == 4'd0 && !out_q.redraw)
    else $error("exit raised away from alarm one home");

endmodule

`default_nettype wire

[src/tacc_step.sv]
// Combinational step of the controller: next alarm state and result for one
// request. Depends on tacc_pkg.
`default_nettype none

module tacc_step (
  input  tacc_pkg::tacc_state_t st_i,
  input  tacc_pkg::tacc_req_t   req_i,
  output tacc_pkg::tacc_state_t nxt_o,
  output tacc_pkg::tacc_res_t   res_o
);
  import tacc_pkg::*;

  logic [1:0] sel;
  logic [1:0] mode;
  logic [1:0] sel_after;
  logic [3:0] home_view;
  logic       editing;
  logic       fired;

  always_comb begin
    nxt_o     = st_i;
    res_o     = '0;
    sel       = view_alarm(st_i.view_mode);
    mode      = view_mode_of(st_i.view_mode);
    home_view = '0;
    editing   = 1'b0;
    fired     = 1'b0;

    if (req_i.func <= FN_DOWN_RIGHT) begin
      if (st_i.ringing[sel]) begin
        nxt_o.ringing[sel] = 1'b0;
        res_o.stop_alert   = 1'b1;
        res_o.redraw       = 1'b1;
      end else begin
        case (req_i.func)
          FN_UP_LEFT: begin
            case (mode)
              MODE_HOME: begin
                if (sel == 2'd0) begin
                  res_o.exit_request = 1'b1;
                end else begin
                  nxt_o.view_mode = view_of(sel - 2'd1, MODE_HOME);
                  res_o.redraw    = 1'b1;
                end
              end
              MODE_HOUR: begin
                nxt_o.hour[sel] = (st_i.hour[sel] == HOUR_MAX) ? 5'd0 : st_i.hour[sel] + 5'd1;
                res_o.redraw    = 1'b1;
              end
              MODE_MINUTE: begin
                nxt_o.minute[sel] = (st_i.minute[sel] == MINUTE_MAX) ? 6'd0
                                                                     : st_i.minute[sel] + 6'd1;
                res_o.redraw      = 1'b1;
              end
              default: ;
            endcase
          end
          FN_UP_RIGHT: begin
            if (mode == MODE_HOME) begin
              nxt_o.enable[sel] = ~st_i.enable[sel];
              res_o.redraw      = 1'b1;
            end
          end
          FN_DOWN_LEFT: begin
            case (mode)
              MODE_HOME: begin
                if (sel < 2'd2) begin
                  nxt_o.view_mode = view_of(sel + 2'd1, MODE_HOME);
                  res_o.redraw    = 1'b1;
                end
              end
              MODE_HOUR: begin
                nxt_o.hour[sel] = (st_i.hour[sel] == 5'd0) ? HOUR_MAX : st_i.hour[sel] - 5'd1;
                res_o.redraw    = 1'b1;
              end
              MODE_MINUTE: begin
                nxt_o.minute[sel] = (st_i.minute[sel] == 6'd0) ? MINUTE_MAX
                                                               : st_i.minute[sel] - 6'd1;
                res_o.redraw      = 1'b1;
              end
              default: ;
            endcase
          end
          default: begin
            if (mode != MODE_NONE) begin
              nxt_o.view_mode = view_of(sel, (mode == MODE_MINUTE) ? MODE_HOME : mode + 2'd1);
              res_o.redraw    = 1'b1;
            end
          end
        endcase
      end
    end else if (req_i.func == FN_TICK) begin
      if (!(st_i.last_hour == req_i.now_hour && st_i.last_minute == req_i.now_minute)) begin
        nxt_o.last_hour   = req_i.now_hour;
        nxt_o.last_minute = req_i.now_minute;
        for (int k = 0; k < NUM_ALARMS; k++) begin
          home_view = view_of(2'(k), MODE_HOME);
          editing   = req_i.in_foreground &&
                      (nxt_o.view_mode == home_view + 4'd1 ||
                       nxt_o.view_mode == home_view + 4'd2);
          if (st_i.enable[k] && !editing && st_i.hour[k] == req_i.now_hour &&
              st_i.minute[k] == req_i.now_minute) begin
            nxt_o.ringing[k] = 1'b1;
            nxt_o.view_mode  = home_view;
            fired            = 1'b1;
          end
        end
        if (fired) begin
          res_o.start_alert = 1'b1;
          if (req_i.in_foreground) begin
            res_o.redraw = 1'b1;
          end else begin
            res_o.launch_request = 1'b1;
          end
        end
      end
      if (|nxt_o.ringing) begin
        nxt_o.blink = ~st_i.blink;
        if (req_i.in_foreground) begin
          res_o.redraw = 1'b1;
        end
      end
    end

    sel_after           = view_alarm(nxt_o.view_mode);
    res_o.view_state    = nxt_o.view_mode;
    res_o.shown_hour    = nxt_o.hour[sel_after];
    res_o.shown_minute  = nxt_o.minute[sel_after];
    res_o.shown_enabled = nxt_o.enable[sel_after];
    res_o.shown_ringing = nxt_o.ringing[sel_after];
    res_o.blink_phase   = nxt_o.blink;
  end

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the three-alarm clock controller: a directed table,
// then random requests, each result checked against its typed row or a predictor.
// Depends on tacc_pkg, tacc_if and three_alarm_clock_controller_top.

module tb_top;
  import tacc_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 500;
  localparam logic [2:0] FN_SPARE_LO = 3'd5;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  typedef struct {
    tacc_req_t req;
    bit        typed;
    tacc_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned src_idle_pct = 20;
  int unsigned sink_idle_pct = 79;
  int unsigned mismatches = 0;

  tacc_res_t pending_results[$];
  stim_row_t directed_rows[$];

  logic [3:0] view_q = '0;
  logic [4:0] hour_q [NUM_ALARMS] = '{default: '0};
  logic [5:0] minute_q [NUM_ALARMS] = '{default: '0};
  logic       enable_q [NUM_ALARMS] = '{default: 1'b0};
  logic       ringing_q [NUM_ALARMS] = '{default: 1'b0};
  logic       blink_q = 1'b0;
  logic [4:0] last_hour_q = HOUR_NONE;
  logic [5:0] last_minute_q = '0;

  tacc_in_if  req_if ();
  tacc_out_if res_if ();

  three_alarm_clock_controller_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  always #6 clk = ~clk;

  function automatic logic [1:0] selected_alarm();
    return (view_q / 3 > 2) ? 2'd2 : 2'(view_q / 3);
  endfunction

  function automatic tacc_res_t alarm_clock_step(input tacc_req_t r);
    tacc_res_t  o;
    logic [1:0] sel;
    logic [1:0] mode;
    logic       fired;
    logic       editing;
    o = '0;
    sel = selected_alarm();
    mode = (view_q <= VIEW_LAST) ? 2'(view_q % 3) : MODE_NONE;
    if (r.func <= FN_DOWN_RIGHT) begin
      if (ringing_q[sel]) begin
        ringing_q[sel] = 1'b0;
        o.stop_alert = 1'b1;
        o.redraw = 1'b1;
      end else if (mode != MODE_NONE) begin
        case (r.func)
          FN_UP_LEFT: begin
            if (mode == MODE_HOME) begin
              if (sel == 2'd0) begin
                o.exit_request = 1'b1;
              end else begin
                view_q = 4'((sel - 1) * 3);
                o.redraw = 1'b1;
              end
            end else if (mode == MODE_HOUR) begin
              hour_q[sel] = (hour_q[sel] == HOUR_MAX) ? '0 : hour_q[sel] + 5'd1;
              o.redraw = 1'b1;
            end else begin
              minute_q[sel] = (minute_q[sel] == MINUTE_MAX) ? '0 : minute_q[sel] + 6'd1;
              o.redraw = 1'b1;
            end
          end
          FN_UP_RIGHT: begin
            if (mode == MODE_HOME) begin
              enable_q[sel] = ~enable_q[sel];
              o.redraw = 1'b1;
            end
          end
          FN_DOWN_LEFT: begin
            if (mode == MODE_HOME) begin
              if (sel < 2'd2) begin
                view_q = 4'((sel + 1) * 3);
                o.redraw = 1'b1;
              end
            end else if (mode == MODE_HOUR) begin
              hour_q[sel] = (hour_q[sel] == '0) ? HOUR_MAX : hour_q[sel] - 5'd1;
              o.redraw = 1'b1;
            end else begin
              minute_q[sel] = (minute_q[sel] == '0) ? MINUTE_MAX : minute_q[sel] - 6'd1;
              o.redraw = 1'b1;
            end
          end
          default: begin
            view_q = 4'(sel * 3) + ((mode == MODE_MINUTE) ? 4'(MODE_HOME) : 4'(mode + 2'd1));
            o.redraw = 1'b1;
          end
        endcase
      end
    end else if (r.func == FN_TICK) begin
      if (!(last_hour_q == r.now_hour && last_minute_q == r.now_minute)) begin
        last_hour_q = r.now_hour;
        last_minute_q = r.now_minute;
        fired = 1'b0;
        for (int k = 0; k < NUM_ALARMS; k++) begin
          editing = r.in_foreground && (view_q == 4'(k * 3 + 1) || view_q == 4'(k * 3 + 2));
          if (enable_q[k] && !editing && hour_q[k] == r.now_hour &&
              minute_q[k] == r.now_minute) begin
            ringing_q[k] = 1'b1;
            view_q = 4'(k * 3);
            fired = 1'b1;
          end
        end
        if (fired) begin
          o.start_alert = 1'b1;
          if (r.in_foreground) o.redraw = 1'b1;
          else o.launch_request = 1'b1;
        end
      end
      if (ringing_q[0] || ringing_q[1] || ringing_q[2]) begin
        blink_q = ~blink_q;
        if (r.in_foreground) o.redraw = 1'b1;
      end
    end
    sel = selected_alarm();
    o.view_state = view_q;
    o.shown_hour = hour_q[sel];
    o.shown_minute = minute_q[sel];
    o.shown_enabled = enable_q[sel];
    o.shown_ringing = ringing_q[sel];
    o.blink_phase = blink_q;
    return o;
  endfunction

  function automatic tacc_req_t random_request();
    tacc_req_t   r;
    int unsigned pick;
    int unsigned k;
    r.now_hour = 5'($urandom);
    r.now_minute = 6'($urandom);
    r.in_foreground = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 50) begin
      r.func = 3'($urandom_range(FN_DOWN_RIGHT, FN_UP_LEFT));
    end else if (pick < 95) begin
      r.func = FN_TICK;
      k = $urandom_range(9);
      if (k < 5) begin
        k = $urandom_range(NUM_ALARMS - 1);
        r.now_hour = hour_q[k];
        r.now_minute = minute_q[k];
      end else if (k < 7) begin
        r.now_hour = last_hour_q;
        r.now_minute = last_minute_q;
      end else if (k < 9) begin
        r.now_hour = 5'($urandom_range(HOUR_MAX));
        r.now_minute = 6'($urandom_range(MINUTE_MAX));
      end
    end else begin
      r.func = 3'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
    end
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] func, input logic [4:0] hour,
                                  input logic [5:0] minute, input logic fg,
                                  input bit typed = 1'b0, input tacc_res_t res = '0);
    stim_row_t row;
    row.req.func = func;
    row.req.now_hour = hour;
    row.req.now_minute = minute;
    row.req.in_foreground = fg;
    row.typed = typed;
    row.res = res;
    directed_rows.push_back(row);
  endfunction

  task automatic send_request(input tacc_req_t r, input bit typed, input tacc_res_t res);
    tacc_res_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk); while (!req_if.ready);
    predicted = alarm_clock_step(r);
    pending_results.push_back(typed ? res : predicted);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result(input tacc_res_t want, input tacc_res_t got);
    check_field("view_state", want.view_state, got.view_state);
    check_field("shown_hour", want.shown_hour, got.shown_hour);
    check_field("shown_minute", want.shown_minute, got.shown_minute);
    check_field("shown_enabled", want.shown_enabled, got.shown_enabled);
    check_field("shown_ringing", want.shown_ringing, got.shown_ringing);
    check_field("blink_phase", want.blink_phase, got.blink_phase);
    check_field("start_alert", want.start_alert, got.start_alert);
    check_field("stop_alert", want.stop_alert, got.stop_alert);
    check_field("exit_request", want.exit_request, got.exit_request);
    check_field("launch_request", want.launch_request, got.launch_request);
    check_field("redraw", want.redraw, got.redraw);
  endtask

  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: no result expected, got %h", $time, res_if.payload);
        mismatches++;
      end else begin
        compare_result(pending_results.pop_front(), res_if.payload);
      end
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.payload = '0;

    // The trailing byte of each typed result holds enabled, ringing, blink, start,
    // stop, exit, launch and redraw, in that order.
    add_row(FN_UP_LEFT, 0, 0, 0, 1'b1, tacc_res_t'({4'd0, 5'd0, 6'd0, 8'b0000_0100}));
    add_row(FN_UP_RIGHT, 0, 0, 0, 1'b1, tacc_res_t'({4'd0, 5'd0, 6'd0, 8'b1000_0001}));
    add_row(FN_DOWN_RIGHT, 0, 0, 0, 1'b1, tacc_res_t'({4'd1, 5'd0, 6'd0, 8'b1000_0001}));
    add_row(FN_DOWN_LEFT, 0, 0, 0, 1'b1, tacc_res_t'({4'd1, 5'd23, 6'd0, 8'b1000_0001}));
    add_row(FN_UP_LEFT, 0, 0, 0, 1'b1, tacc_res_t'({4'd1, 5'd0, 6'd0, 8'b1000_0001}));
    add_row(FN_DOWN_RIGHT, 0, 0, 0, 1'b1, tacc_res_t'({4'd2, 5'd0, 6'd0, 8'b1000_0001}));
    add_row(FN_DOWN_LEFT, 0, 0, 0, 1'b1, tacc_res_t'({4'd2, 5'd0, 6'd59, 8'b1000_0001}));
    add_row(FN_UP_LEFT, 0, 0, 0, 1'b1, tacc_res_t'({4'd2, 5'd0, 6'd0, 8'b1000_0001}));
    add_row(FN_UP_RIGHT, 0, 0, 0);
    add_row(FN_DOWN_RIGHT, 0, 0, 0);
    add_row(FN_TICK, 0, 0, 1);
    add_row(FN_TICK, 0, 0, 0);
    add_row(FN_DOWN_RIGHT, 31, 63, 1);
    add_row(FN_UP_RIGHT, 0, 0, 0);
    add_row(FN_DOWN_LEFT, 0, 0, 0);
    add_row(FN_UP_RIGHT, 0, 0, 0);
    add_row(FN_DOWN_LEFT, 0, 0, 0);
    add_row(FN_DOWN_LEFT, 0, 0, 0);
    add_row(FN_UP_RIGHT, 0, 0, 0);
    add_row(FN_UP_LEFT, 0, 0, 0);
    add_row(FN_DOWN_RIGHT, 0, 0, 0);
    add_row(FN_TICK, 31, 63, 1);
    add_row(FN_TICK, 0, 0, 1);
    add_row(FN_TICK, 31, 63, 0);
    add_row(FN_TICK, 0, 0, 0);
    add_row(FN_SPARE_LO, 21, 42, 1);
    add_row(FN_SPARE_HI, 10, 21, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    end
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS / 3) begin
        src_idle_pct = 79;
        sink_idle_pct = 20;
      end else if (i == 2 * RANDOM_REQUESTS / 3) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      send_request(random_request(), 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
src/tacc_pkg.sv
src/tacc_if.sv
src/tacc_step.sv
src/three_alarm_clock_controller_top.sv
test/tb_top.sv
